// ===== hdl/microwire_eeprom_master_assert.svh =====
// assertion macros for the microwire eeprom master
// included by the top level, expects i_clk and i_rst_n in scope
`ifndef MICROWIRE_EEPROM_MASTER_ASSERT_SVH
`define MICROWIRE_EEPROM_MASTER_ASSERT_SVH

// same-cycle implication
`define MWE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MWE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/mwe_pkg.sv =====
// shared types, codes and helpers for the microwire eeprom master
// no dependencies
`default_nettype none

package mwe_pkg;

    localparam int DATA_BITS        = 16;
    localparam int MAX_ADDRESS_BITS = 8;
    localparam int TIMEOUT_BITS     = 24;
    localparam int MIN_ADDRESS_BITS = 6;
    localparam int PAT_W            = DATA_BITS + MAX_ADDRESS_BITS + 3;

    localparam logic [1:0] OP_READ    = 2'd0;
    localparam logic [1:0] OP_WRITE   = 2'd1;
    localparam logic [1:0] OP_WEN     = 2'd2;
    localparam logic [1:0] OP_WDS     = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_DUMMY   = 2'd2;
    localparam logic [1:0] ST_TIMEOUT = 2'd3;

    localparam logic [1:0] REG_ADDR_BITS = 2'd0;
    localparam logic [1:0] REG_HALF      = 2'd1;
    localparam logic [1:0] REG_TIMEOUT   = 2'd2;

    typedef struct packed {
        logic [3:0]              address_bits;
        logic [15:0]             half_period;
        logic [TIMEOUT_BITS-1:0] timeout;
    } t_cfg;

    typedef struct packed {
        logic                 serial_data_in;
        logic [15:0]          write_data;
        logic [7:0]           word_address;
        logic [1:0]           operation;
        logic                 command_valid;
    } t_item;

    typedef struct packed {
        logic [15:0] read_data;
        logic [1:0]  status;
        logic        done_res;
        logic        ready_res;
        logic        serial_data_out;
        logic        serial_clock;
        logic        chip_select;
    } t_result;

    function automatic logic pat_bit(input logic [PAT_W-1:0] pat, input logic [4:0] pos);
        logic r;
        r = 1'b0;
        if (int'(pos) < PAT_W) begin
            r = pat[pos];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/mwe_regs.sv =====
// apb configuration registers of the microwire eeprom master
// depends on mwe_pkg
`default_nettype none

module mwe_regs (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic      [31:0]   prdata,
    output logic               pready,
    output mwe_pkg::t_cfg      o_cfg
);

    logic [3:0]                        r_addr_bits;
    logic [15:0]                       r_half;
    logic [mwe_pkg::TIMEOUT_BITS-1:0]  r_timeout;
    logic                              wr_en;
    logic [1:0]                        reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr_bits <= 4'd6;
            r_half      <= 16'd100;
            r_timeout   <= mwe_pkg::TIMEOUT_BITS'(2500000);
        end else if (wr_en) begin
            case (reg_idx)
                mwe_pkg::REG_ADDR_BITS: r_addr_bits <= pwdata[3:0];
                mwe_pkg::REG_HALF:      r_half      <= pwdata[15:0];
                mwe_pkg::REG_TIMEOUT:   r_timeout   <= pwdata[mwe_pkg::TIMEOUT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            mwe_pkg::REG_ADDR_BITS: prdata = 32'(r_addr_bits);
            mwe_pkg::REG_HALF:      prdata = 32'(r_half);
            mwe_pkg::REG_TIMEOUT:   prdata = 32'(r_timeout);
            default:                prdata = 32'd0;
        endcase
    end

    assign o_cfg.address_bits = r_addr_bits;
    assign o_cfg.half_period  = r_half;
    assign o_cfg.timeout      = r_timeout;

endmodule

`default_nettype wire

// ===== hdl/mwe_seq.sv =====
// bit-level microwire sequencer, one step per accepted tick
// depends on mwe_pkg
`default_nettype none

module mwe_seq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_step,
    input  wire mwe_pkg::t_item  i_item,
    input  wire mwe_pkg::t_cfg   i_cfg,
    output mwe_pkg::t_result     o_res
);

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_SHIFT_LOW  = 4'd1,
        PH_SHIFT_HIGH = 4'd2,
        PH_SETTLE     = 4'd3,
        PH_READ_LOW   = 4'd4,
        PH_READ_HIGH  = 4'd5,
        PH_PROG_GAP   = 4'd6,
        PH_POLL       = 4'd7,
        PH_CLEAR      = 4'd8,
        PH_FINISH     = 4'd9
    } t_phase;

    localparam int PW = mwe_pkg::PAT_W;
    localparam int TW = mwe_pkg::TIMEOUT_BITS;

    t_phase           r_phase, n_phase;
    logic [1:0]       r_cmd, n_cmd;
    logic [4:0]       r_bitcnt, n_bitcnt;
    logic [PW-1:0]    r_pattern, n_pattern;
    logic [15:0]      r_div, n_div;
    logic [TW-1:0]    r_wait, n_wait;
    logic [15:0]      r_rx, n_rx;
    logic             r_cs, n_cs, r_sk, n_sk, r_di, n_di;
    logic [1:0]       r_status, n_status;
    logic             n_done;

    logic [3:0]       eff_n;
    logic [15:0]      half_m1;
    logic [TW-1:0]    limit;
    logic             addr_oor;
    logic [TW-1:0]    wait_inc;
    logic [4:0]       bit_dec;

    always_comb begin
        if (i_cfg.address_bits < 4'(mwe_pkg::MIN_ADDRESS_BITS)) begin
            eff_n = 4'(mwe_pkg::MIN_ADDRESS_BITS);
        end else if (i_cfg.address_bits > 4'(mwe_pkg::MAX_ADDRESS_BITS)) begin
            eff_n = 4'(mwe_pkg::MAX_ADDRESS_BITS);
        end else begin
            eff_n = i_cfg.address_bits;
        end
    end

    assign half_m1  = (i_cfg.half_period == 16'd0) ? 16'd0 : i_cfg.half_period - 16'd1;
    assign limit    = (i_cfg.timeout == '0) ? TW'(1) : i_cfg.timeout;
    assign addr_oor = ((i_item.word_address >> eff_n) != 8'd0);
    assign wait_inc = r_wait + TW'(1);
    assign bit_dec  = r_bitcnt - 5'd1;

    always_comb begin
        n_phase   = r_phase;
        n_cmd     = r_cmd;
        n_bitcnt  = r_bitcnt;
        n_pattern = r_pattern;
        n_div     = r_div;
        n_wait    = r_wait;
        n_rx      = r_rx;
        n_cs      = r_cs;
        n_sk      = r_sk;
        n_di      = r_di;
        n_status  = r_status;
        n_done    = 1'b0;
        case (r_phase)
            PH_IDLE: begin
                if (i_item.command_valid) begin
                    if (!i_item.operation[1] && addr_oor) begin
                        n_status = mwe_pkg::ST_RANGE;
                        n_done   = 1'b1;
                    end else begin
                        case (i_item.operation)
                            mwe_pkg::OP_READ: begin
                                n_pattern = (PW'(1) << (eff_n + 4'd2)) | (PW'(2) << eff_n)
                                          | PW'(i_item.word_address);
                                n_bitcnt  = 5'(eff_n) + 5'd3;
                            end
                            mwe_pkg::OP_WRITE: begin
                                n_pattern = (((PW'(1) << (eff_n + 4'd2)) | (PW'(1) << eff_n)
                                          | PW'(i_item.word_address)) << mwe_pkg::DATA_BITS)
                                          | PW'(i_item.write_data[mwe_pkg::DATA_BITS-1:0]);
                                n_bitcnt  = 5'(eff_n) + 5'd3 + 5'(mwe_pkg::DATA_BITS);
                            end
                            mwe_pkg::OP_WEN: begin
                                n_pattern = PW'(5'h13) << (eff_n - 4'd2);
                                n_bitcnt  = 5'(eff_n) + 5'd3;
                            end
                            default: begin
                                n_pattern = PW'(1) << (eff_n + 4'd2);
                                n_bitcnt  = 5'(eff_n) + 5'd3;
                            end
                        endcase
                        // first bit out is always the start bit
                        n_cmd   = i_item.operation;
                        n_wait  = '0;
                        n_cs    = 1'b1;
                        n_sk    = 1'b0;
                        n_di    = 1'b1;
                        n_phase = PH_SHIFT_LOW;
                        n_div   = half_m1;
                    end
                end
            end
            PH_POLL: begin
                if (i_item.serial_data_in) begin
                    n_cs    = 1'b1;
                    n_sk    = 1'b1;
                    n_di    = 1'b1;
                    n_phase = PH_CLEAR;
                    n_div   = half_m1;
                end else begin
                    n_wait = wait_inc;
                    if (wait_inc >= limit) begin
                        n_status = mwe_pkg::ST_TIMEOUT;
                        n_cs     = 1'b0;
                        n_sk     = 1'b0;
                        n_di     = 1'b1;
                        n_phase  = PH_FINISH;
                        n_div    = half_m1;
                    end
                end
            end
            default: begin
                if (r_div != 16'd0) begin
                    n_div = r_div - 16'd1;
                end else begin
                    case (r_phase)
                        PH_SHIFT_LOW: begin
                            n_sk    = 1'b1;
                            n_phase = PH_SHIFT_HIGH;
                            n_div   = half_m1;
                        end
                        PH_SHIFT_HIGH: begin
                            n_bitcnt = bit_dec;
                            if (bit_dec != 5'd0) begin
                                n_sk    = 1'b0;
                                n_di    = mwe_pkg::pat_bit(r_pattern, bit_dec - 5'd1);
                                n_phase = PH_SHIFT_LOW;
                                n_div   = half_m1;
                            end else if (r_cmd == mwe_pkg::OP_READ) begin
                                n_phase = PH_SETTLE;
                                n_div   = half_m1;
                            end else if (r_cmd == mwe_pkg::OP_WRITE) begin
                                n_cs    = 1'b0;
                                n_sk    = 1'b0;
                                n_phase = PH_PROG_GAP;
                                n_div   = half_m1;
                            end else begin
                                n_status = mwe_pkg::ST_OK;
                                n_cs     = 1'b0;
                                n_sk     = 1'b0;
                                n_phase  = PH_FINISH;
                                n_div    = half_m1;
                            end
                        end
                        PH_SETTLE: begin
                            if (i_item.serial_data_in) begin
                                n_status = mwe_pkg::ST_DUMMY;
                                n_cs     = 1'b0;
                                n_sk     = 1'b0;
                                n_phase  = PH_FINISH;
                            end else begin
                                n_pattern = '0;
                                n_bitcnt  = 5'(mwe_pkg::DATA_BITS);
                                n_cs      = 1'b1;
                                n_sk      = 1'b0;
                                n_di      = 1'b1;
                                n_phase   = PH_READ_LOW;
                            end
                            n_div = half_m1;
                        end
                        PH_READ_LOW: begin
                            n_cs    = 1'b1;
                            n_sk    = 1'b1;
                            n_di    = 1'b1;
                            n_phase = PH_READ_HIGH;
                            n_div   = half_m1;
                        end
                        PH_READ_HIGH: begin
                            n_pattern = {1'b0, r_pattern[PW-3:0], i_item.serial_data_in};
                            n_bitcnt  = bit_dec;
                            n_div     = half_m1;
                            if (bit_dec != 5'd0) begin
                                n_cs    = 1'b1;
                                n_sk    = 1'b0;
                                n_di    = 1'b1;
                                n_phase = PH_READ_LOW;
                            end else begin
                                n_rx     = 16'(n_pattern[mwe_pkg::DATA_BITS-1:0]);
                                n_status = mwe_pkg::ST_OK;
                                n_cs     = 1'b0;
                                n_sk     = 1'b0;
                                n_di     = 1'b1;
                                n_phase  = PH_FINISH;
                            end
                        end
                        PH_PROG_GAP: begin
                            n_cs    = 1'b1;
                            n_sk    = 1'b0;
                            n_di    = 1'b1;
                            n_wait  = '0;
                            n_phase = PH_POLL;
                        end
                        PH_CLEAR: begin
                            n_status = mwe_pkg::ST_OK;
                            n_cs     = 1'b0;
                            n_sk     = 1'b0;
                            n_di     = 1'b1;
                            n_phase  = PH_FINISH;
                            n_div    = half_m1;
                        end
                        default: begin
                            n_phase = PH_IDLE;
                            n_div   = 16'd0;
                            n_done  = 1'b1;
                        end
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_cmd     <= 2'd0;
            r_bitcnt  <= 5'd0;
            r_pattern <= '0;
            r_div     <= 16'd0;
            r_wait    <= '0;
            r_rx      <= 16'd0;
            r_cs      <= 1'b0;
            r_sk      <= 1'b0;
            r_di      <= 1'b0;
            r_status  <= mwe_pkg::ST_OK;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_cmd     <= n_cmd;
            r_bitcnt  <= n_bitcnt;
            r_pattern <= n_pattern;
            r_div     <= n_div;
            r_wait    <= n_wait;
            r_rx      <= n_rx;
            r_cs      <= n_cs;
            r_sk      <= n_sk;
            r_di      <= n_di;
            r_status  <= n_status;
        end
    end

    assign o_res.chip_select     = n_cs;
    assign o_res.serial_clock    = n_sk;
    assign o_res.serial_data_out = n_di;
    assign o_res.ready_res       = (n_phase == PH_IDLE);
    assign o_res.done_res        = n_done;
    assign o_res.status          = n_status;
    assign o_res.read_data       = n_rx;

endmodule

`default_nettype wire

// ===== hdl/microwire_eeprom_master.sv =====
// top level of the microwire eeprom master: stream ports, apb registers, result register
// depends on mwe_pkg, mwe_regs, mwe_seq and microwire_eeprom_master_assert.svh
//
//  channel   dir   content
//  s_*       in    one tick beat: command, address, write data, sampled DO
//  m_*       out   one result beat per tick: pins, ready, done, status, read word
//  apb       in    address_bits, half_period_ticks, program_timeout_ticks
//
// one input beat is taken every cycle unless the output stalls, each yields one registered result beat
// the result register frees as its beat is taken, so input and output overlap
// a stalled output holds the input side until the result register drains
// reset is synchronous: sequencer idle, pins low, registers at their defaults
`default_nettype none
`include "microwire_eeprom_master_assert.svh"

module microwire_eeprom_master (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // command_valid, operation[2], word_address[8], write_data[16], serial_data_in, pad
    input  wire logic [31:0] i_s_tdata,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // chip_select, serial_clock, serial_data_out, ready_res, done_res, status[2],
    // read_data[16], pad
    output logic      [23:0] o_m_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    mwe_pkg::t_cfg    cfg;
    mwe_pkg::t_item   item;
    mwe_pkg::t_result res;
    logic             in_beat;
    logic             r_m_valid;
    logic [22:0]      r_m_data;

    assign item       = mwe_pkg::t_item'(i_s_tdata[27:0]);
    assign o_s_tready = !r_m_valid || i_m_tready;
    assign in_beat    = i_s_tvalid && o_s_tready;

    mwe_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mwe_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (in_beat),
        .i_item  (item),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (in_beat) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_m_data <= res;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {1'b0, r_m_data};

    `MWE_ASSERT_NEXT(a_beat_gives_result, in_beat, r_m_valid, "accepted beat gave no result")
    `MWE_ASSERT_NOW(a_sk_needs_cs, r_m_valid && r_m_data[1], r_m_data[0], "sk high with cs low")
    `MWE_ASSERT_NOW(a_done_is_idle, r_m_valid && r_m_data[4], r_m_data[3], "done while busy")

endmodule

`default_nettype wire

// ===== dv/microwire_eeprom_master_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for microwire_eeprom_master: tick beats in, pin/status beats out
// predicts every result beat from a behavioral sequencer and compares it field by field
// depends on mwe_pkg and the microwire_eeprom_master rtl

module microwire_eeprom_master_tb;

    typedef enum logic [3:0] {
        SEQ_IDLE, SEQ_SHIFT_LOW, SEQ_SHIFT_HIGH, SEQ_SETTLE, SEQ_READ_LOW,
        SEQ_READ_HIGH, SEQ_PROG_GAP, SEQ_POLL, SEQ_CLEAR, SEQ_FINISH
    } t_seq;

    localparam int CLK_PERIOD       = 8;
    localparam int RUN_LIMIT_CYCLES = 2_000_000;
    localparam int DRAIN_CYCLES     = 16;
    localparam int MAX_PRINTED      = 40;
    localparam int RANDOM_BATCHES   = 1;
    localparam int BATCH_COMMANDS   = 2;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata  = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [23:0] o_m_tdata;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [3:0]  paddr      = '0;
    logic [31:0] pwdata     = '0;
    logic [31:0] prdata;
    logic        pready;

    int send_gap_pct   = 33;
    int ready_drop_pct = 52;
    int mismatch_count = 0;

    // configuration and sequencer state as the predictor sees them
    logic [3:0]  cfg_addr_bits = 4'd6;
    logic [15:0] cfg_half      = 16'd100;
    logic [23:0] cfg_timeout   = 24'd2500000;
    t_seq        mdl_phase     = SEQ_IDLE;
    logic [1:0]  mdl_cmd       = '0;
    logic [4:0]  mdl_bits      = '0;
    logic [31:0] mdl_pat       = '0;
    logic [15:0] mdl_div       = '0;
    logic [23:0] mdl_wait      = '0;
    logic [15:0] mdl_word      = '0;
    logic        mdl_cs        = 1'b0;
    logic        mdl_sk        = 1'b0;
    logic        mdl_di        = 1'b0;
    logic [1:0]  mdl_status    = mwe_pkg::ST_OK;

    // how the eeprom answers on DO for the command in flight
    logic [15:0] line_word        = '0;
    logic        line_dummy       = 1'b0;
    int          line_ready_after = 0;

    mwe_pkg::t_result tick_outcomes[$];

    microwire_eeprom_master dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic int addr_len();
        int n;
        n = int'(cfg_addr_bits);
        if (n < mwe_pkg::MIN_ADDRESS_BITS) n = mwe_pkg::MIN_ADDRESS_BITS;
        if (n > mwe_pkg::MAX_ADDRESS_BITS) n = mwe_pkg::MAX_ADDRESS_BITS;
        return n;
    endfunction

    function automatic void enter_phase(input t_seq p);
        mdl_phase = p;
        mdl_div = (cfg_half == 16'd0) ? 16'd0 : cfg_half - 16'd1;
    endfunction

    function automatic void set_lines(input logic cs, input logic sk, input logic di);
        mdl_cs = cs;
        mdl_sk = sk;
        mdl_di = di;
    endfunction

    function automatic logic next_out_bit();
        return mdl_pat[mdl_bits - 5'd1];
    endfunction

    function automatic void end_command(input logic di, input logic [1:0] st);
        mdl_status = st;
        set_lines(1'b0, 1'b0, di);
        enter_phase(SEQ_FINISH);
    endfunction

    function automatic logic start_command(input mwe_pkg::t_item it);
        int n;
        logic [31:0] hdr;
        n = addr_len();
        if ((it.operation == mwe_pkg::OP_READ || it.operation == mwe_pkg::OP_WRITE) &&
            int'(it.word_address) >= (1 << n)) begin
            mdl_status = mwe_pkg::ST_RANGE;
            return 1'b1;
        end
        case (it.operation)
            mwe_pkg::OP_READ: begin
                mdl_pat = (32'd1 << (n + 2)) | (32'd2 << n) | 32'(it.word_address);
                mdl_bits = 5'(n + 3);
            end
            mwe_pkg::OP_WRITE: begin
                hdr = (32'd1 << (n + 2)) | (32'd1 << n) | 32'(it.word_address);
                mdl_pat = (hdr << mwe_pkg::DATA_BITS) | 32'(it.write_data);
                mdl_bits = 5'(n + 3 + mwe_pkg::DATA_BITS);
            end
            mwe_pkg::OP_WEN: begin
                mdl_pat = 32'h13 << (n - 2);
                mdl_bits = 5'(n + 3);
            end
            default: begin
                mdl_pat = 32'd1 << (n + 2);
                mdl_bits = 5'(n + 3);
            end
        endcase
        mdl_cmd = it.operation;
        mdl_wait = '0;
        set_lines(1'b1, 1'b0, next_out_bit());
        enter_phase(SEQ_SHIFT_LOW);
        return 1'b0;
    endfunction

    function automatic logic segment_end(input logic dout);
        logic done;
        done = 1'b0;
        case (mdl_phase)
            SEQ_SHIFT_LOW: begin
                set_lines(1'b1, 1'b1, mdl_di);
                enter_phase(SEQ_SHIFT_HIGH);
            end
            SEQ_SHIFT_HIGH: begin
                mdl_bits = mdl_bits - 5'd1;
                if (mdl_bits != 5'd0) begin
                    set_lines(1'b1, 1'b0, next_out_bit());
                    enter_phase(SEQ_SHIFT_LOW);
                end else if (mdl_cmd == mwe_pkg::OP_READ) begin
                    enter_phase(SEQ_SETTLE);
                end else if (mdl_cmd == mwe_pkg::OP_WRITE) begin
                    set_lines(1'b0, 1'b0, mdl_di);
                    enter_phase(SEQ_PROG_GAP);
                end else begin
                    end_command(mdl_di, mwe_pkg::ST_OK);
                end
            end
            SEQ_SETTLE: begin
                if (dout) begin
                    end_command(mdl_di, mwe_pkg::ST_DUMMY);
                end else begin
                    mdl_pat = '0;
                    mdl_bits = 5'(mwe_pkg::DATA_BITS);
                    set_lines(1'b1, 1'b0, 1'b1);
                    enter_phase(SEQ_READ_LOW);
                end
            end
            SEQ_READ_LOW: begin
                set_lines(1'b1, 1'b1, 1'b1);
                enter_phase(SEQ_READ_HIGH);
            end
            SEQ_READ_HIGH: begin
                mdl_pat = {mdl_pat[30:0], dout} & 32'h03FF_FFFF;
                mdl_bits = mdl_bits - 5'd1;
                if (mdl_bits != 5'd0) begin
                    set_lines(1'b1, 1'b0, 1'b1);
                    enter_phase(SEQ_READ_LOW);
                end else begin
                    mdl_word = mdl_pat[15:0];
                    end_command(1'b1, mwe_pkg::ST_OK);
                end
            end
            SEQ_PROG_GAP: begin
                set_lines(1'b1, 1'b0, 1'b1);
                mdl_wait = '0;
                mdl_phase = SEQ_POLL;
            end
            SEQ_CLEAR: begin
                end_command(1'b1, mwe_pkg::ST_OK);
            end
            default: begin
                mdl_phase = SEQ_IDLE;
                mdl_div = '0;
                done = 1'b1;
            end
        endcase
        return done;
    endfunction

    function automatic mwe_pkg::t_result eeprom_tick(input mwe_pkg::t_item it);
        mwe_pkg::t_result r;
        logic done;
        logic [23:0] limit;
        done = 1'b0;
        limit = (cfg_timeout == 24'd0) ? 24'd1 : cfg_timeout;
        if (mdl_phase == SEQ_IDLE) begin
            if (it.command_valid) done = start_command(it);
        end else if (mdl_phase == SEQ_POLL) begin
            if (it.serial_data_in) begin
                set_lines(1'b1, 1'b1, 1'b1);
                enter_phase(SEQ_CLEAR);
            end else begin
                mdl_wait = mdl_wait + 24'd1;
                if (mdl_wait >= limit) end_command(1'b1, mwe_pkg::ST_TIMEOUT);
            end
        end else if (mdl_div != 16'd0) begin
            mdl_div = mdl_div - 16'd1;
        end else begin
            done = segment_end(it.serial_data_in);
        end
        r.chip_select     = mdl_cs;
        r.serial_clock    = mdl_sk;
        r.serial_data_out = mdl_di;
        r.ready_res       = (mdl_phase == SEQ_IDLE);
        r.done_res        = done;
        r.status          = mdl_status;
        r.read_data       = mdl_word;
        return r;
    endfunction

    // DO level the eeprom would show on the coming tick
    function automatic logic do_pin_level();
        if (mdl_phase == SEQ_SETTLE && mdl_div == 16'd0) return line_dummy;
        if (mdl_phase == SEQ_READ_HIGH && mdl_div == 16'd0) return line_word[mdl_bits - 5'd1];
        if (mdl_phase == SEQ_POLL) return int'(mdl_wait) >= line_ready_after;
        return 1'($urandom_range(1));
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    endtask

    task automatic compare_beat(input mwe_pkg::t_result got, input mwe_pkg::t_result want);
        if (got.chip_select !== want.chip_select)
            report_mismatch("chip_select", 16'(got.chip_select), 16'(want.chip_select));
        if (got.serial_clock !== want.serial_clock)
            report_mismatch("serial_clock", 16'(got.serial_clock), 16'(want.serial_clock));
        if (got.serial_data_out !== want.serial_data_out)
            report_mismatch("serial_data_out", 16'(got.serial_data_out),
                            16'(want.serial_data_out));
        if (got.ready_res !== want.ready_res)
            report_mismatch("ready_res", 16'(got.ready_res), 16'(want.ready_res));
        if (got.done_res !== want.done_res)
            report_mismatch("done_res", 16'(got.done_res), 16'(want.done_res));
        if (got.status !== want.status)
            report_mismatch("status", 16'(got.status), 16'(want.status));
        if (got.read_data !== want.read_data)
            report_mismatch("read_data", got.read_data, want.read_data);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (tick_outcomes.size() == 0)
                report_mismatch("beat with nothing expected", o_m_tdata[22:7], 16'd0);
            else
                compare_beat(o_m_tdata[22:0], tick_outcomes.pop_front());
        end
        i_m_tready <= ($urandom_range(99) >= ready_drop_pct);
    end

    task automatic send_tick(input logic cv, input logic [1:0] op, input logic [7:0] addr,
                             input logic [15:0] data);
        mwe_pkg::t_item it;
        it.command_valid  = cv;
        it.operation      = op;
        it.word_address   = addr;
        it.write_data     = data;
        it.serial_data_in = do_pin_level();
        while ($urandom_range(99) < send_gap_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {4'b0, it};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        tick_outcomes.push_back(eeprom_tick(it));
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (tick_outcomes.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            mwe_pkg::REG_ADDR_BITS: cfg_addr_bits = value[3:0];
            mwe_pkg::REG_HALF:      cfg_half = value[15:0];
            mwe_pkg::REG_TIMEOUT:   cfg_timeout = value[23:0];
            default: ;
        endcase
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // one command from its first tick until the sequencer is idle again
    task automatic issue(input logic [1:0] op, input logic [7:0] addr, input logic [15:0] data,
                         input logic [15:0] word, input logic dummy, input int ready_after,
                         input int noise_pct);
        line_word = word;
        line_dummy = dummy;
        line_ready_after = ready_after;
        send_tick(1'b1, op, addr, data);
        while (mdl_phase != SEQ_IDLE)
            send_tick($urandom_range(99) < noise_pct, 2'($urandom), 8'($urandom),
                      16'($urandom));
    endtask

    task automatic test_reset_defaults();
        send_tick(1'b0, mwe_pkg::OP_READ, 8'h00, 16'h0000);
        issue(mwe_pkg::OP_READ, 8'd64, 16'h0000, 16'h0000, 1'b0, 0, 0);
        issue(mwe_pkg::OP_WRITE, 8'hFF, 16'hFFFF, 16'h0000, 1'b0, 0, 0);
        send_tick(1'b0, mwe_pkg::OP_WRITE, 8'h00, 16'h0000);
    endtask

    task automatic test_read_word();
        wait_drained();
        write_reg(mwe_pkg::REG_HALF, 32'd1);
        issue(mwe_pkg::OP_READ, 8'h2A, 16'h0000, 16'hA5C3, 1'b0, 0, 0);
        // dummy bit high aborts and keeps the old word
        issue(mwe_pkg::OP_READ, 8'h15, 16'h0000, 16'h1234, 1'b1, 0, 0);
    endtask

    task automatic test_write_word();
        wait_drained();
        write_reg(mwe_pkg::REG_TIMEOUT, 32'd8);
        issue(mwe_pkg::OP_WRITE, 8'd63, 16'hFFFF, 16'h0000, 1'b0, 3, 0);
        wait_drained();
        write_reg(mwe_pkg::REG_TIMEOUT, 32'd0);
        issue(mwe_pkg::OP_WRITE, 8'd9, 16'h8001, 16'h0000, 1'b0, 5, 0);
    endtask

    task automatic test_address_length();
        wait_drained();
        write_reg(mwe_pkg::REG_ADDR_BITS, 32'd0);
        issue(mwe_pkg::OP_READ, 8'd64, 16'h0000, 16'h0000, 1'b0, 0, 0);
        wait_drained();
        write_reg(mwe_pkg::REG_ADDR_BITS, 32'd15);
        issue(mwe_pkg::OP_WEN, 8'h00, 16'h0000, 16'h0000, 1'b0, 0, 0);
        wait_drained();
        write_reg(mwe_pkg::REG_ADDR_BITS, 32'd7);
        issue(mwe_pkg::OP_READ, 8'd128, 16'h0000, 16'h0000, 1'b0, 0, 0);
    endtask

    task automatic test_half_period_edges();
        wait_drained();
        write_reg(mwe_pkg::REG_HALF, 32'd0);
        issue(mwe_pkg::OP_WDS, 8'h00, 16'h0000, 16'h0000, 1'b0, 0, 0);
        wait_drained();
        write_reg(mwe_pkg::REG_HALF, 32'd2);
    endtask

    task automatic test_busy_ignored();
        issue(mwe_pkg::OP_WEN, 8'd77, 16'hC3C3, 16'h0000, 1'b0, 4, 100);
    endtask

    task automatic test_random_traffic(input int gap_pct, input int drop_pct);
        int n;
        int roll;
        logic [1:0] op;
        logic [7:0] addr;
        send_gap_pct = gap_pct;
        ready_drop_pct = drop_pct;
        for (int b = 0; b < RANDOM_BATCHES; b++) begin
            wait_drained();
            write_reg(mwe_pkg::REG_ADDR_BITS, $urandom_range(15));
            write_reg(mwe_pkg::REG_HALF, $urandom_range(1));
            write_reg(mwe_pkg::REG_TIMEOUT,
                      ($urandom_range(7) == 0) ? 32'hFF_FFFF : $urandom_range(12));
            n = addr_len();
            for (int c = 0; c < BATCH_COMMANDS; c++) begin
                repeat ($urandom_range(2))
                    send_tick(1'b0, 2'($urandom), 8'($urandom), 16'($urandom));
                roll = $urandom_range(99);
                op = (roll < 35) ? mwe_pkg::OP_READ : (roll < 70) ? mwe_pkg::OP_WRITE :
                     (roll < 85) ? mwe_pkg::OP_WEN : mwe_pkg::OP_WDS;
                addr = ($urandom_range(4) == 0) ? 8'($urandom_range(255)) :
                       8'($urandom_range((1 << n) - 1));
                issue(op, addr, 16'($urandom), 16'($urandom), $urandom_range(9) == 0,
                      $urandom_range(45), 25);
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_read_word();
        test_write_word();
        test_address_length();
        test_half_period_edges();
        test_busy_ignored();
        test_random_traffic(33, 52);
        test_random_traffic(52, 33);
        test_random_traffic(0, 0);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS microwire_eeprom_master");
        end else begin
            $display("FAIL microwire_eeprom_master");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_CYCLES * CLK_PERIOD);
        $display("FAIL microwire_eeprom_master");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/mwe_pkg.sv
hdl/mwe_regs.sv
hdl/mwe_seq.sv
hdl/microwire_eeprom_master.sv
dv/microwire_eeprom_master_tb.sv
